[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds, cons holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

// Once ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hw/rtl/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and constants for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 32;
   localparam int CMD_W     = 4;
   localparam int NUM_W     = DATA_W + FRAC_BITS;
   localparam int DIV_STEPS = NUM_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_LT       = 4'd4,
      CMD_LE       = 4'd5,
      CMD_GT       = 4'd6,
      CMD_GE       = 4'd7,
      CMD_EQ       = 4'd8,
      CMD_NE       = 4'd9,
      CMD_MIN      = 4'd10,
      CMD_MAX      = 4'd11,
      CMD_FROM_INT = 4'd12,
      CMD_TO_INT   = 4'd13
   } cmd_type;

   // Payload carried down the divider pipeline
   typedef struct packed {
      cmd_type                  cmd;
      logic [DATA_W-1:0]        val;
      logic                     cond;
      logic signed [2*DATA_W-1:0] prod;
      logic [NUM_W-1:0]         num;
      logic [DATA_W:0]          rem;
      logic [DATA_W-1:0]        den;
      logic [NUM_W-1:0]         quot;
      logic                     neg;
   } stage_type;

endpackage

[hw/rtl/fpa_req_if.sv]
// ----------------------------------------------------------------------------
// fpa_req_if
// Request channel: command and two raw operands.
// ----------------------------------------------------------------------------
interface fpa_req_if;
   logic                                valid;
   logic                                ready;
   logic [fpa_pkg::CMD_W-1:0]           cmd;
   logic signed [fpa_pkg::DATA_W-1:0]   operand_a;
   logic signed [fpa_pkg::DATA_W-1:0]   operand_b;

   modport source (output valid, cmd, operand_a, operand_b, input ready);
   modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

[hw/rtl/fpa_rsp_if.sv]
// ----------------------------------------------------------------------------
// fpa_rsp_if
// Response channel: result value and flags.
// ----------------------------------------------------------------------------
interface fpa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fpa_pkg::DATA_W-1:0]   value_out;
   logic                                cond_true;
   logic                                div_zero;

   modport source (output valid, value_out, cond_true, div_zero, input ready);
   modport sink   (input valid, value_out, cond_true, div_zero, output ready);
endinterface

[hw/rtl/fixed_point_alu_unit.sv]
// Path from request to response: input register, setup stage, divider stages, output register.
// Throughput: one word per cycle unless the response stalls; the restoring divider
// retires one quotient bit per stage, which sets the depth.
// A stalled response holds the whole pipeline in place.
// Reset (synchronous, active high) clears all valid bits.
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Pipelined signed fixed-point ALU: add, sub, mul, div, compare, min/max, convert.
// ----------------------------------------------------------------------------
module fixed_point_alu_unit (
   input  logic          clock,
   input  logic          reset,
   fpa_req_if.sink       req_ch,
   fpa_rsp_if.source     rsp_ch
);

   localparam int N = fpa_pkg::DIV_STEPS;
   localparam int W = fpa_pkg::DATA_W;
   localparam int F = fpa_pkg::FRAC_BITS;

   logic advance;

   // input register
   logic                    in_valid_ff;
   fpa_pkg::cmd_type        in_cmd_ff;
   logic signed [W-1:0]     in_a_ff;
   logic signed [W-1:0]     in_b_ff;

   // divider pipeline, stage 0 is the setup stage
   logic                    stg_valid_ff [0:N];
   fpa_pkg::stage_type      stg_ff       [0:N];
   fpa_pkg::stage_type      setup_in;

   // output register
   logic                    out_valid_ff;
   logic signed [W-1:0]     out_val_ff, out_val_in;
   logic                    out_cond_ff, out_dz_ff, out_dz_in;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // capture request word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_ch.valid;
      end
      if (advance) begin
         in_cmd_ff <= fpa_pkg::cmd_type'(req_ch.cmd);
         in_a_ff   <= req_ch.operand_a;
         in_b_ff   <= req_ch.operand_b;
      end
   end

   // setup: simple ops, product, divider operands
   always_comb begin
      logic [W-1:0] abs_a;
      setup_in      = '0;
      setup_in.cmd  = in_cmd_ff;
      abs_a         = in_a_ff[W-1] ? W'(-in_a_ff) : W'(in_a_ff);
      setup_in.num  = {abs_a, {F{1'b0}}};
      setup_in.den  = in_b_ff[W-1] ? W'(-in_b_ff) : W'(in_b_ff);
      setup_in.neg  = in_a_ff[W-1] ^ in_b_ff[W-1];
      setup_in.prod = (2*W)'(in_a_ff) * (2*W)'(in_b_ff);
      case (in_cmd_ff)
         fpa_pkg::CMD_ADD:      setup_in.val  = W'(in_a_ff + in_b_ff);
         fpa_pkg::CMD_SUB:      setup_in.val  = W'(in_a_ff - in_b_ff);
         fpa_pkg::CMD_LT:       setup_in.cond = in_a_ff <  in_b_ff;
         fpa_pkg::CMD_LE:       setup_in.cond = in_a_ff <= in_b_ff;
         fpa_pkg::CMD_GT:       setup_in.cond = in_a_ff >  in_b_ff;
         fpa_pkg::CMD_GE:       setup_in.cond = in_a_ff >= in_b_ff;
         fpa_pkg::CMD_EQ:       setup_in.cond = in_a_ff == in_b_ff;
         fpa_pkg::CMD_NE:       setup_in.cond = in_a_ff != in_b_ff;
         fpa_pkg::CMD_MIN:      setup_in.val  = (in_a_ff > in_b_ff) ? in_b_ff : in_a_ff;
         fpa_pkg::CMD_MAX:      setup_in.val  = (in_a_ff > in_b_ff) ? in_a_ff : in_b_ff;
         fpa_pkg::CMD_FROM_INT: setup_in.val  = in_a_ff <<< F;
         fpa_pkg::CMD_TO_INT:   setup_in.val  = in_a_ff >>> F;
         default:               setup_in.val  = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         stg_valid_ff[0] <= in_valid_ff;
      end
      if (advance) begin
         stg_ff[0] <= setup_in;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar k = 0; k < N; k++) begin : g_div
      fpa_pkg::stage_type step_in;
      always_comb begin
         logic [W:0] r2;
         logic       ge;
         step_in      = stg_ff[k];
         r2           = {stg_ff[k].rem[W-1:0], stg_ff[k].num[fpa_pkg::NUM_W-1]};
         ge           = r2 >= {1'b0, stg_ff[k].den};
         step_in.rem  = ge ? (r2 - {1'b0, stg_ff[k].den}) : r2;
         step_in.num  = {stg_ff[k].num[fpa_pkg::NUM_W-2:0], 1'b0};
         step_in.quot = {stg_ff[k].quot[fpa_pkg::NUM_W-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            stg_valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            stg_valid_ff[k+1] <= stg_valid_ff[k];
         end
         if (advance) begin
            stg_ff[k+1] <= step_in;
         end
      end
   end

   // final selection
   always_comb begin
      logic signed [2*W-1:0] shifted;
      logic [W-1:0]          q32;
      shifted    = stg_ff[N].prod >>> F;
      q32        = stg_ff[N].quot[W-1:0];
      out_dz_in  = 1'b0;
      out_val_in = stg_ff[N].val;
      case (stg_ff[N].cmd)
         fpa_pkg::CMD_MUL: out_val_in = shifted[W-1:0];
         fpa_pkg::CMD_DIV: begin
            if (stg_ff[N].den == '0) begin
               out_dz_in  = 1'b1;
               out_val_in = '0;
            end else begin
               out_val_in = stg_ff[N].neg ? W'(-q32) : q32;
            end
         end
         default: out_val_in = stg_ff[N].val;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= stg_valid_ff[N];
      end
      if (advance) begin
         out_val_ff  <= out_val_in;
         out_cond_ff <= stg_ff[N].cond;
         out_dz_ff   <= out_dz_in;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.value_out = out_val_ff;
   assign rsp_ch.cond_true = out_cond_ff;
   assign rsp_ch.div_zero  = out_dz_ff;

endmodule

[hw/rtl/fpa_checker.sv]
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks on the fixed-point ALU response channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpa_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [fpa_pkg::DATA_W-1:0] rsp_value_out,
   input logic                       rsp_cond_true,
   input logic                       rsp_div_zero
);

   // a held word stays offered
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // divide by zero returns zero
   `ASSERT_IMPLIES(a_dz_zero, clock, reset, rsp_valid && rsp_div_zero, rsp_value_out == '0)
   // a true comparison returns zero value
   `ASSERT_IMPLIES(a_cond_zero, clock, reset, rsp_valid && rsp_cond_true, rsp_value_out == '0)
   // a word never has both cond_true and div_zero set
   `ASSERT_IMPLIES(a_excl, clock, reset, rsp_valid, !(rsp_cond_true && rsp_div_zero))

endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_value_out (rsp_ch.value_out),
   .rsp_cond_true (rsp_ch.cond_true),
   .rsp_div_zero  (rsp_ch.div_zero)
);

[verif/tb_fixed_point_alu_unit.sv]
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_unit
// Drives command words into the fixed-point ALU under several idle and stall
// patterns, predicts each response from the operands or takes it from the table,
// and compares it field by field, in order. A directed table covers the extremes,
// every command and the special cases; random words follow.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_unit;

   localparam int LATENCY   = fpa_pkg::DIV_STEPS + 3;
   localparam int MAX_CYCLE = 400000;

   // Idle patterns, per phase
   localparam int PH_NONE  = 0;
   localparam int PH_SEND  = 1;
   localparam int PH_RECV  = 2;
   localparam int PH_BOTH  = 3;
   localparam int PH_HOLD  = 4;

   // Command codes with no operation behind them
   localparam logic [fpa_pkg::CMD_W-1:0] CMD_SPARE_LO = 4'd14;
   localparam logic [fpa_pkg::CMD_W-1:0] CMD_SPARE_HI = 4'd15;

   typedef struct packed {
      logic [fpa_pkg::DATA_W-1:0] value;
      logic                       cond;
      logic                       dz;
   } alu_result_type;

   typedef struct {
      logic [fpa_pkg::CMD_W-1:0]  cmd;
      logic [fpa_pkg::DATA_W-1:0] a;
      logic [fpa_pkg::DATA_W-1:0] b;
      bit                         typed;
      alu_result_type             res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fpa_req_if req_ch ();
   fpa_rsp_if rsp_ch ();

   fixed_point_alu_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #2 clock = ~clock;

   alu_result_type pending_results[$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             phase       = PH_NONE;
   int             hold_left   = 0;
   stim_row_type   table_rows[$];

   // Report one mismatch and count it
   task automatic report_mismatch(input string what,
                                  input logic [fpa_pkg::DATA_W-1:0] got,
                                  input logic [fpa_pkg::DATA_W-1:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // Result of one command word
   function automatic alu_result_type alu_compute(
         input logic [fpa_pkg::CMD_W-1:0]  cmd,
         input logic [fpa_pkg::DATA_W-1:0] a_raw,
         input logic [fpa_pkg::DATA_W-1:0] b_raw);
      alu_result_type     r;
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] prod;
      logic signed [63:0] quot;
      r    = '0;
      a    = 64'(signed'(a_raw));
      b    = 64'(signed'(b_raw));
      prod = a * b;
      case (cmd)
         fpa_pkg::CMD_ADD:      r.value = a_raw + b_raw;
         fpa_pkg::CMD_SUB:      r.value = a_raw - b_raw;
         fpa_pkg::CMD_MUL:      r.value = fpa_pkg::DATA_W'(prod >>> fpa_pkg::FRAC_BITS);
         fpa_pkg::CMD_DIV: begin
            if (b == 0) r.dz = 1'b1;
            else begin
               quot    = (a <<< fpa_pkg::FRAC_BITS) / b;
               r.value = quot[fpa_pkg::DATA_W-1:0];
            end
         end
         fpa_pkg::CMD_LT:       r.cond = a < b;
         fpa_pkg::CMD_LE:       r.cond = a <= b;
         fpa_pkg::CMD_GT:       r.cond = a > b;
         fpa_pkg::CMD_GE:       r.cond = a >= b;
         fpa_pkg::CMD_EQ:       r.cond = a == b;
         fpa_pkg::CMD_NE:       r.cond = a != b;
         fpa_pkg::CMD_MIN:      r.value = (a > b) ? b_raw : a_raw;
         fpa_pkg::CMD_MAX:      r.value = (a > b) ? a_raw : b_raw;
         fpa_pkg::CMD_FROM_INT: r.value = a_raw << fpa_pkg::FRAC_BITS;
         fpa_pkg::CMD_TO_INT:   r.value = fpa_pkg::DATA_W'(a >>> fpa_pkg::FRAC_BITS);
         default:               r = '0;
      endcase
      return r;
   endfunction

   function automatic stim_row_type mk_row(input logic [fpa_pkg::CMD_W-1:0] cmd,
                                           input logic [fpa_pkg::DATA_W-1:0] a,
                                           input logic [fpa_pkg::DATA_W-1:0] b,
                                           input bit typed,
                                           input logic [fpa_pkg::DATA_W-1:0] v,
                                           input logic c,
                                           input logic dz);
      stim_row_type row;
      row.cmd = cmd; row.a = a; row.b = b; row.typed = typed;
      row.res = '{v, c, dz};
      return row;
   endfunction

   // Random operand, biased towards edges and small values
   function automatic logic [fpa_pkg::DATA_W-1:0] rand_operand();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000 + $urandom_range(0, 3);
         1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2:       return $urandom_range(0, 4) - 2;
         3:       return $urandom_range(0, 4096) - 2048;
         default: return $urandom;
      endcase
   endfunction

   // Cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("tb_fixed_point_alu_unit failed");
         $finish;
      end
   end

   // Response check at the rising edge
   always @(posedge clock) begin
      alu_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", rsp_ch.value_out, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.value_out !== want.value)
               report_mismatch("value_out", rsp_ch.value_out, want.value);
            if (rsp_ch.cond_true !== want.cond)
               report_mismatch("cond_true", 32'(rsp_ch.cond_true), 32'(want.cond));
            if (rsp_ch.div_zero !== want.dz)
               report_mismatch("div_zero", 32'(rsp_ch.div_zero), 32'(want.dz));
         end
      end
   end

   // Receiver ready, changed at the falling edge
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else begin
         case (phase)
            PH_RECV: rsp_ch.ready <= ($urandom_range(0, 99) >= 86);
            PH_BOTH: rsp_ch.ready <= ($urandom_range(0, 99) >= 31);
            default: rsp_ch.ready <= 1'b1;
         endcase
      end
   end

   // Offer one word and wait until it is taken
   task automatic send_word(input logic [fpa_pkg::CMD_W-1:0] cmd,
                            input logic [fpa_pkg::DATA_W-1:0] a,
                            input logic [fpa_pkg::DATA_W-1:0] b, input bit typed,
                            input alu_result_type typed_res);
      int idle_pct;
      idle_pct = (phase == PH_SEND) ? 86 : (phase == PH_BOTH) ? 31 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= cmd;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_results.push_back(typed ? typed_res : alu_compute(cmd, a, b));
      @(negedge clock);
   endtask

   initial begin
      int n;
      int phase_len;
      logic [fpa_pkg::CMD_W-1:0] cmd;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = '0;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      rsp_ch.ready     = 1'b0;

      // Directed table: typed results where obvious, else predicted
      table_rows.push_back(mk_row(fpa_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'd1, 1,
                                  32'h8000_0000, 0, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_SUB, 32'h8000_0000, 32'd1, 1,
                                  32'h7FFF_FFFF, 0, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_MUL, 32'h0000_0100, 32'h0000_0100, 1,
                                  32'h100, 0, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 0,
                                  0, 0, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0,
                                  0, 0, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_DIV, 32'h1234_5678, 32'd0, 1,
                                  32'd0, 0, 1));
      table_rows.push_back(mk_row(fpa_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0,
                                  0, 0, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_DIV, 32'h7FFF_FFFF, 32'd1, 0, 0, 0, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_DIV, 32'hFFFF_FF00, 32'd3, 0, 0, 0, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_LT, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                                  0, 1, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_LE, 32'd5, 32'd5, 1, 0, 1, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_GT, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                                  0, 0, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_GE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                                  0, 1, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_EQ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                                  0, 1, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_NE, 32'h0, 32'h8000_0000, 1, 0, 1, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_MIN, 32'd7, 32'd7, 1, 32'd7, 0, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                                  32'h7FFF_FFFF, 0, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_FROM_INT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1,
                                  32'hFFFF_FF00, 0, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_TO_INT, 32'hFFFF_FFFF, 32'h0, 1,
                                  32'hFFFF_FFFF, 0, 0));
      table_rows.push_back(mk_row(fpa_pkg::CMD_TO_INT, 32'h8000_0000, 32'h0, 0, 0, 0, 0));
      table_rows.push_back(mk_row(CMD_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                                  0, 0, 0));
      table_rows.push_back(mk_row(CMD_SPARE_HI, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                                  0, 0, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (table_rows[i])
         send_word(table_rows[i].cmd, table_rows[i].a, table_rows[i].b,
                   table_rows[i].typed, table_rows[i].res);

      // Random words through each idle pattern; one long receiver hold-off
      for (int p = PH_NONE; p <= PH_HOLD; p++) begin
         phase     = (p == PH_HOLD) ? PH_NONE : p;
         phase_len = (p == PH_HOLD) ? 120 : 160;
         if (p == PH_HOLD) hold_left <= 300;
         for (n = 0; n < phase_len; n++) begin
            cmd = ($urandom_range(0, 19) == 0)
                     ? fpa_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI))
                     : fpa_pkg::CMD_W'($urandom_range(fpa_pkg::CMD_ADD,
                                                      fpa_pkg::CMD_TO_INT));
            send_word(cmd, rand_operand(), rand_operand(), 0, '0);
         end
      end
      req_ch.valid <= 1'b0;
      phase        = PH_NONE;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("tb_fixed_point_alu_unit passed");
      else
         $display("tb_fixed_point_alu_unit failed");
      $finish;
   end

endmodule
